>>> rtl/cla_pkg.sv
`timescale 1ns / 1ps

package cla_pkg;

    localparam int LINE_BYTES = 256;
    localparam int PTR_W      = $clog2(LINE_BYTES);
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] MODE_COMMAND = 2'd0;
    localparam logic [1:0] MODE_NEWLINE = 2'd1;
    localparam logic [1:0] MODE_RAW     = 2'd2;

    typedef enum logic [1:0] {
        CMD_RX        = 2'd0,
        CMD_READ_NEXT = 2'd1,
        CMD_READ_AT   = 2'd2,
        CMD_FLUSH     = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_STORED     = 4'd0,
        ST_ERASED     = 4'd1,
        ST_OVERFLOW   = 4'd2,
        ST_READY      = 4'd3,
        ST_BLANK      = 4'd4,
        ST_NEWLINE    = 4'd5,
        ST_READ_OK    = 4'd6,
        ST_READ_EMPTY = 4'd7,
        ST_FLUSHED    = 4'd8
    } status_t;

    // Classified command word passed from the front end to the executor.
    typedef struct packed {
        cmd_t       cmd;
        logic       is_erase;
        logic       is_eol;
        logic       is_quote;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } op_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data_byte;
        logic [7:0] position;
        logic [7:0] newline_at;
        logic [7:0] fill_count;
    } result_t;

    function automatic result_t make_result(
        input status_t          st,
        input logic [7:0]       data,
        input logic [7:0]       pos,
        input logic [PTR_W-1:0] nl,
        input logic [PTR_W-1:0] fill
    );
        result_t r;
        r.status     = st;
        r.data_byte  = data;
        r.position   = pos;
        r.newline_at = 8'(nl);
        r.fill_count = 8'(fill);
        return r;
    endfunction

endpackage

>>> rtl/cla_queue.sv
`timescale 1ns / 1ps

module cla_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cla_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output cla_pkg::op_t  pop_op
);
    import cla_pkg::*;

    op_t             entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign full   = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/cla_front.sv
`timescale 1ns / 1ps

module cla_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output cla_pkg::op_t  q_op
);
    import cla_pkg::*;

    logic [7:0] ch;

    assign ch       = s_tdata[7:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Tag the character classes once so the executor only sees flags.
    always_comb begin
        q_op.cmd        = cmd_t'(s_tuser);
        q_op.rx_byte    = ch;
        q_op.read_index = s_tdata[15:8];
        q_op.is_erase   = (ch == CH_BS) || (ch == CH_DEL);
        q_op.is_eol     = (ch == CH_CR) || (ch == CH_LF);
        q_op.is_quote   = (ch == CH_QUOTE);
    end

endmodule

>>> rtl/cla_back.sv
`timescale 1ns / 1ps

module cla_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              op_valid,
    input  cla_pkg::op_t      op,
    output logic              op_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output cla_pkg::result_t  m_result
);
    import cla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } state_t;

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(LINE_BYTES - 1);

    state_t           state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [PTR_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] rdpos_reg, rdpos_next;
    logic [PTR_W-1:0] nlpos_reg, nlpos_next;
    logic             quote_reg, quote_next;
    logic [7:0]       pos_reg, pos_next;
    logic [PTR_W-1:0] scan_idx_reg, scan_idx_next;
    logic             scan_chk_reg, scan_chk_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic [7:0]       line_mem [LINE_BYTES];
    logic [LINE_BYTES-1:0] vld_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic [7:0]       rd_byte;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;

    logic             slot_free;
    logic             edit_mode;
    logic             do_mark, do_erase, do_eol;
    logic [PTR_W-1:0] fill_dec;
    logic             idx_ok;

    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;
    assign slot_free = !out_valid_reg || m_ready;
    assign rd_byte   = rd_vld_reg ? rd_data_reg : CH_NUL;

    assign edit_mode = (mode_reg != MODE_NEWLINE) && (mode_reg != MODE_RAW);
    assign do_mark   = (mode_reg == MODE_NEWLINE) && (nlpos_reg == '0) && op.is_eol;
    assign do_erase  = edit_mode && op.is_erase;
    assign do_eol    = edit_mode && !op.is_erase && op.is_eol && !quote_reg;
    assign fill_dec  = (fill_reg != '0) ? fill_reg - 1'b1 : fill_reg;
    assign idx_ok    = ({{PTR_W{1'b0}}, op.read_index} < {8'd0, nlpos_reg});

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        fill_next      = fill_reg;
        rdpos_next     = rdpos_reg;
        nlpos_next     = nlpos_reg;
        quote_next     = quote_reg;
        pos_next       = pos_reg;
        scan_idx_next  = scan_idx_reg;
        scan_chk_next  = scan_chk_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        op_pop         = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = fill_reg;
        wr_data        = op.rx_byte;
        rd_en          = 1'b0;
        rd_addr        = rdpos_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (op_valid && slot_free) begin
                    op_pop = 1'b1;
                    unique case (op.cmd)
                        CMD_RX: begin
                            if (do_mark) begin
                                nlpos_next     = fill_reg;
                                rdpos_next     = fill_reg;
                                out_valid_next = 1'b1;
                                out_next       = make_result(ST_NEWLINE, op.rx_byte,
                                                    8'(fill_reg), fill_reg, fill_reg);
                            end else if (do_erase) begin
                                fill_next      = fill_dec;
                                out_valid_next = 1'b1;
                                out_next       = make_result(ST_ERASED, op.rx_byte,
                                                    8'(fill_dec), nlpos_reg, fill_dec);
                            end else if (do_eol) begin
                                // terminate the line, then scan it for a printable byte
                                wr_en         = 1'b1;
                                wr_data       = CH_NUL;
                                pos_next      = 8'(fill_reg);
                                fill_next     = '0;
                                quote_next    = 1'b0;
                                scan_idx_next = '0;
                                scan_chk_next = 1'b0;
                                state_next    = S_SCAN;
                            end else if (fill_reg == LAST_POS) begin
                                out_valid_next = 1'b1;
                                out_next       = make_result(ST_OVERFLOW, op.rx_byte,
                                                    8'(fill_reg), nlpos_reg, fill_reg);
                            end else begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                if (edit_mode && op.is_quote) begin
                                    quote_next = !quote_reg;
                                end
                                out_valid_next = 1'b1;
                                out_next       = make_result(ST_STORED, op.rx_byte,
                                                    8'(fill_reg), nlpos_reg, fill_reg + 1'b1);
                            end
                        end
                        CMD_READ_NEXT: begin
                            if (rdpos_reg < fill_reg) begin
                                rd_en      = 1'b1;
                                rd_addr    = rdpos_reg;
                                pos_next   = 8'(rdpos_reg);
                                rdpos_next = rdpos_reg + 1'b1;
                                state_next = S_READ;
                            end else begin
                                out_valid_next = 1'b1;
                                out_next       = make_result(ST_READ_EMPTY, CH_NUL,
                                                    8'(rdpos_reg), nlpos_reg, fill_reg);
                            end
                        end
                        CMD_READ_AT: begin
                            if (idx_ok) begin
                                rd_en      = 1'b1;
                                rd_addr    = PTR_W'(op.read_index);
                                pos_next   = op.read_index;
                                state_next = S_READ;
                            end else begin
                                out_valid_next = 1'b1;
                                out_next       = make_result(ST_READ_EMPTY, CH_NUL,
                                                    op.read_index, nlpos_reg, fill_reg);
                            end
                        end
                        CMD_FLUSH: begin
                            fill_next      = '0;
                            rdpos_next     = '0;
                            nlpos_next     = '0;
                            quote_next     = 1'b0;
                            out_valid_next = 1'b1;
                            out_next       = make_result(ST_FLUSHED, CH_NUL, 8'd0, '0, '0);
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                out_valid_next = 1'b1;
                out_next       = make_result(ST_READ_OK, rd_byte, pos_reg,
                                    nlpos_reg, fill_reg);
                state_next     = S_IDLE;
            end
            S_SCAN: begin
                // issue one read per cycle, check the byte fetched last cycle
                rd_en         = 1'b1;
                rd_addr       = scan_idx_reg;
                scan_idx_next = scan_idx_reg + 1'b1;
                scan_chk_next = 1'b1;
                if (scan_chk_reg) begin
                    if (rd_byte > CH_SPACE) begin
                        out_valid_next = 1'b1;
                        out_next       = make_result(ST_READY, CH_NUL, pos_reg,
                                            nlpos_reg, fill_reg);
                        state_next     = S_IDLE;
                    end else if (rd_byte == CH_NUL) begin
                        out_valid_next = 1'b1;
                        out_next       = make_result(ST_BLANK, CH_NUL, pos_reg,
                                            nlpos_reg, fill_reg);
                        state_next     = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_wr_en) begin
            mode_next  = cfg_wr_data;
            fill_next  = '0;
            rdpos_next = '0;
            nlpos_next = '0;
            quote_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_COMMAND;
            fill_reg      <= '0;
            rdpos_reg     <= '0;
            nlpos_reg     <= '0;
            quote_reg     <= 1'b0;
            scan_chk_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            fill_reg      <= fill_next;
            rdpos_reg     <= rdpos_next;
            nlpos_reg     <= nlpos_next;
            quote_reg     <= quote_next;
            scan_chk_reg  <= scan_chk_next;
            out_valid_reg <= out_valid_next;
        end
        pos_reg      <= pos_next;
        scan_idx_reg <= scan_idx_next;
        out_reg      <= out_next;
    end

    // Entries never written read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

endmodule

>>> rtl/command_line_assembler.sv
`timescale 1ns / 1ps
// Channel   Direction  tdata                                          tuser
// s_*       in         [7:0] rx_byte, [15:8] read_index                [1:0] cmd
// m_*       out        [7:0] data_byte, [15:8] position,               [3:0] status
//                      [23:16] newline_at, [31:24] fill_count
// cfg_*     in         cfg_wr_data = line_mode, written when cfg_wr_en is high
//
// Receive (other than end of line), erase, flush and empty reads finish in the executor's
// idle state; a read that hits the line store passes through a read state (registered memory read port).
// End of line scans the stored bytes up to the first printable byte or NUL, at most
// LINE_BYTES of them, one store read per cycle.
// Reset is synchronous; store valid bits all clear at once, no clearing pass.
// A two-word queue sits between intake and executor, so s_tready stays high
// for up to two more words while a result waits on m_tready.

module command_line_assembler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte, read_index
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_byte, position, newline_at, fill_count
    output logic [3:0]  m_tuser    // status
);
    import cla_pkg::*;

    logic    q_push, q_full, q_pop, q_empty;
    op_t     push_op, pop_op;
    result_t result;

    cla_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    cla_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .pop_op  (pop_op)
    );

    cla_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op_valid    (!q_empty),
        .op          (pop_op),
        .op_pop      (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {result.fill_count, result.newline_at, result.position,
                      result.data_byte};

endmodule

>>> tb/command_line_assembler_test.sv
`timescale 1ns / 1ps

module command_line_assembler_test;

    import cla_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'd0;
    logic [1:0]  s_tuser     = 2'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    command_line_assembler dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Predicted state of the line buffer
    logic [7:0] text_buf [LINE_BYTES];
    int         text_fill;
    int         read_ptr;
    int         mark_pos;
    bit         quote_open;
    logic [1:0] mode_reg;

    result_t    pending_results [$];
    int         words_sent     = 0;
    int         mismatch_count = 0;
    int         src_idle_pct   = 0;
    int         snk_idle_pct   = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("status", {4'd0, m_tuser}, {4'd0, want.status});
                check_field("data_byte", m_tdata[7:0], want.data_byte);
                check_field("position", m_tdata[15:8], want.position);
                check_field("newline_at", m_tdata[23:16], want.newline_at);
                check_field("fill_count", m_tdata[31:24], want.fill_count);
            end
        end
    end

    function automatic status_t keep_byte(logic [7:0] ch);
        if (text_fill >= LINE_BYTES - 1)
            return ST_OVERFLOW;
        text_buf[text_fill] = ch;
        text_fill++;
        return ST_STORED;
    endfunction

    function automatic result_t predict_line_result(cmd_t c, logic [7:0] ch, logic [7:0] idx);
        result_t r;
        logic    eol;
        int      len;
        bit      found;
        eol = (ch == CH_CR) || (ch == CH_LF);
        r.data_byte = 8'd0;
        r.position  = 8'd0;
        case (c)
            CMD_RX: begin
                r.data_byte = ch;
                if (mode_reg == MODE_RAW) begin
                    r.position = 8'(text_fill);
                    r.status   = keep_byte(ch);
                end else if (mode_reg == MODE_NEWLINE && mark_pos == 0 && eol) begin
                    // a mark at zero leaves the next CR or LF free to mark again
                    mark_pos   = text_fill;
                    read_ptr   = text_fill;
                    r.status   = ST_NEWLINE;
                    r.position = 8'(text_fill);
                end else if (mode_reg == MODE_NEWLINE) begin
                    r.position = 8'(text_fill);
                    r.status   = keep_byte(ch);
                end else if (ch == CH_BS || ch == CH_DEL) begin
                    if (text_fill > 0)
                        text_fill--;
                    r.status   = ST_ERASED;
                    r.position = 8'(text_fill);
                end else if (!quote_open && eol) begin
                    len = text_fill;
                    text_buf[len] = CH_NUL;
                    quote_open = 1'b0;
                    text_fill  = 0;
                    found      = 1'b0;
                    for (int i = 0; i < LINE_BYTES; i++) begin
                        if (text_buf[i] > CH_SPACE) begin
                            found = 1'b1;
                            break;
                        end
                        if (text_buf[i] == CH_NUL)
                            break;
                    end
                    r.status    = found ? ST_READY : ST_BLANK;
                    r.data_byte = 8'd0;
                    r.position  = 8'(len);
                end else begin
                    r.position = 8'(text_fill);
                    r.status   = keep_byte(ch);
                    if (r.status == ST_STORED && ch == CH_QUOTE)
                        quote_open = !quote_open;
                end
            end
            CMD_READ_NEXT: begin
                if (read_ptr < text_fill) begin
                    r.status    = ST_READ_OK;
                    r.data_byte = text_buf[read_ptr];
                    r.position  = 8'(read_ptr);
                    read_ptr++;
                end else begin
                    r.status   = ST_READ_EMPTY;
                    r.position = 8'(read_ptr);
                end
            end
            CMD_READ_AT: begin
                r.position = idx;
                if (int'(idx) < mark_pos) begin
                    r.status    = ST_READ_OK;
                    r.data_byte = text_buf[idx];
                end else begin
                    r.status = ST_READ_EMPTY;
                end
            end
            default: begin
                // flush keeps the buffer contents
                text_fill  = 0;
                read_ptr   = 0;
                mark_pos   = 0;
                quote_open = 1'b0;
                r.status   = ST_FLUSHED;
            end
        endcase
        r.newline_at = 8'(mark_pos);
        r.fill_count = 8'(text_fill);
        return r;
    endfunction

    // Leaves s_tvalid high after the handshake so back-to-back words need no toggle.
    task automatic send_word(cmd_t c, logic [7:0] ch, logic [7:0] idx);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, ch};
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        pending_results.push_back(predict_line_result(c, ch, idx));
    endtask

    task automatic send_rx(logic [7:0] ch);
        send_word(CMD_RX, ch, 8'($urandom));
    endtask

    task automatic send_read();
        int hi;
        hi = (mark_pos < LINE_BYTES - 1) ? mark_pos + 1 : LINE_BYTES - 1;
        if ($urandom_range(1))
            send_word(CMD_READ_NEXT, 8'($urandom), 8'($urandom));
        else if ($urandom_range(99) < 60)
            send_word(CMD_READ_AT, 8'($urandom), 8'($urandom_range(hi)));
        else
            send_word(CMD_READ_AT, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_line_mode(logic [1:0] mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        mode_reg    = mode;
        text_fill   = 0;
        read_ptr    = 0;
        mark_pos    = 0;
        quote_open  = 1'b0;
    endtask

    task automatic test_command_editing();
        set_line_mode(MODE_COMMAND);
        send_rx("a");
        send_rx(CH_BS);
        send_rx(CH_DEL);            // erase on an empty line
        send_rx(CH_QUOTE);
        send_rx(CH_CR);             // quoted, so stored
        send_rx(CH_QUOTE);
        send_rx(CH_LF);
        send_rx(CH_SPACE);
        send_rx(CH_NUL);            // NUL ahead of the printable byte makes the line blank
        send_rx("x");
        send_rx(CH_CR);
        send_word(CMD_READ_NEXT, 8'hFF, 8'h00);
        send_rx(8'hFF);
        send_word(CMD_READ_NEXT, 8'h00, 8'hFF);
        send_word(CMD_FLUSH, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_newline_marking();
        set_line_mode(MODE_NEWLINE);
        send_rx(CH_LF);
        send_rx(CH_CR);
        send_rx("x");
        send_rx("y");
        send_rx(CH_CR);
        send_rx(CH_LF);
        send_word(CMD_READ_AT, 8'($urandom), 8'd1);
        send_word(CMD_READ_AT, 8'($urandom), 8'd2);
        send_word(CMD_READ_AT, 8'($urandom), 8'hFF);
        send_word(CMD_READ_NEXT, 8'($urandom), 8'($urandom));
        send_word(CMD_READ_NEXT, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_raw_and_spare_mode();
        set_line_mode(MODE_RAW);
        send_rx(CH_CR);
        send_rx(CH_BS);
        send_rx(8'h80);
        set_line_mode(MODE_SPARE);
        send_rx("z");
        send_rx("q");
        send_rx(CH_DEL);
        send_rx(CH_LF);
    endtask

    task automatic test_line_overflow();
        set_line_mode(MODE_RAW);
        repeat (LINE_BYTES + 2)
            send_rx(8'($urandom));
        repeat (2)
            send_word(CMD_READ_NEXT, 8'($urandom), 8'($urandom));
        // all spaces up to the last slot: longest scan before the line turns out ready
        set_line_mode(MODE_COMMAND);
        repeat (LINE_BYTES - 2)
            send_rx(CH_SPACE);
        repeat (3)
            send_rx(8'($urandom_range(8'h41, 8'h5A)));
        send_rx(CH_CR);
        send_word(CMD_READ_NEXT, 8'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] pick_line_char();
        int k;
        k = $urandom_range(99);
        if (k < 70) return 8'($urandom_range(8'h21, 8'h7E));
        if (k < 82) return CH_SPACE;
        if (k < 85) return CH_QUOTE;
        if (k < 90) return $urandom_range(1) ? CH_BS : CH_DEL;
        if (k < 93) return CH_NUL;
        return 8'($urandom);
    endfunction

    task automatic test_random_traffic(int n_words);
        int stop_at;
        int k;
        int len;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(99) < 8)
                set_line_mode(2'($urandom_range(3)));
            k = $urandom_range(99);
            if (k < 70) begin
                len = $urandom_range(99);
                if (len < 85)      len = $urandom_range(12);
                else if (len < 95) len = $urandom_range(13, 60);
                else               len = $urandom_range(200, 280);
                repeat (len)
                    send_rx(pick_line_char());
                send_rx($urandom_range(1) ? CH_CR : CH_LF);
                repeat ($urandom_range(3))
                    send_read();
                if ($urandom_range(99) < 15)
                    send_word(CMD_FLUSH, 8'($urandom), 8'($urandom));
            end else if (k < 90) begin
                repeat ($urandom_range(1, 4))
                    send_read();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(cmd_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        foreach (text_buf[i])
            text_buf[i] = 8'h00;
        text_fill  = 0;
        read_ptr   = 0;
        mark_pos   = 0;
        quote_open = 1'b0;
        mode_reg   = MODE_COMMAND;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 14;
        snk_idle_pct = 47;
        test_command_editing();
        test_newline_marking();
        test_raw_and_spare_mode();
        test_line_overflow();
        test_random_traffic(250);

        src_idle_pct = 47;
        snk_idle_pct = 14;
        test_random_traffic(250);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(250);

        wait_idle();
        // an end-of-line scan is the slowest thing the block does
        repeat (LINE_BYTES + 16) @(posedge aclk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/cla_pkg.sv
rtl/cla_queue.sv
rtl/cla_front.sv
rtl/cla_back.sv
rtl/command_line_assembler.sv
tb/command_line_assembler_test.sv
